[hw/rtl/cevv_pkg.sv]
// ----------------------------------------------------------------------------
// cevv_pkg
// Shared types and constants of the csr edge view validator.
// ----------------------------------------------------------------------------
package cevv_pkg;

    localparam logic [2:0] ERR_NONE  = 3'd0;
    localparam logic [2:0] ERR_RANGE = 3'd1;
    localparam logic [2:0] ERR_ORDER = 3'd2;
    localparam logic [2:0] ERR_DUP   = 3'd3;
    localparam logic [2:0] ERR_BACK  = 3'd4;

    localparam logic [1:0] MODE_LOWER   = 2'd0;
    localparam logic [1:0] MODE_UPPER   = 2'd1;
    localparam logic [1:0] MODE_FORWARD = 2'd2;

    localparam logic [1:0] REG_NODE_COUNT     = 2'd0;
    localparam logic [1:0] REG_VIEW_MODE      = 2'd1;
    localparam logic [1:0] REG_EXPECTED_EDGES = 2'd2;

    localparam logic [63:0] MIX_GOLDEN = 64'h9e3779b97f4a7c15;
    localparam logic [63:0] MIX_MUL_A  = 64'hbf58476d1ce4e5b9;
    localparam logic [63:0] MIX_MUL_B  = 64'h94d049bb133111eb;

    typedef struct packed {
        logic [30:0] node_total;
        logic [1:0]  view_mode;
        logic [30:0] expected_edges;
    } cfg_t;

    // one queue entry: an edge key to hash, or an end marker with its error
    typedef struct packed {
        logic        is_end;
        logic [2:0]  err;
        logic [63:0] key;
    } qentry_t;

endpackage

[hw/rtl/cevv_in_if.sv]
// ----------------------------------------------------------------------------
// cevv_in_if
// Input channel: one edge entry or end-of-stream marker per beat.
// ----------------------------------------------------------------------------
interface cevv_in_if;
    logic               valid;
    logic               ready;
    logic               req_type;
    logic [30:0]        source_node;
    logic signed [31:0] target_node;
    logic [30:0]        src_deg;
    logic [30:0]        tgt_deg;

    modport source (
        output valid, req_type, source_node, target_node, src_deg, tgt_deg,
        input  ready
    );
    modport sink (
        input  valid, req_type, source_node, target_node, src_deg, tgt_deg,
        output ready
    );
endinterface

[hw/rtl/cevv_out_if.sv]
// ----------------------------------------------------------------------------
// cevv_out_if
// Result channel: one fingerprint and status per beat.
// ----------------------------------------------------------------------------
interface cevv_out_if;
    logic        valid;
    logic        ready;
    logic [30:0] edge_count;
    logic [63:0] hash_sum;
    logic [63:0] hash_xor;
    logic [2:0]  error_code;
    logic        count_match;

    modport source (
        output valid, edge_count, hash_sum, hash_xor, error_code, count_match,
        input  ready
    );
    modport sink (
        input  valid, edge_count, hash_sum, hash_xor, error_code, count_match,
        output ready
    );
endinterface

[hw/rtl/csr_edge_view_validator_unit.sv]
// ----------------------------------------------------------------------------
// csr_edge_view_validator_unit
// Validates one view of a csr edge list and builds a splitmix64 fingerprint.
//
//   channel  | kind      | beat carries
//   ---------+-----------+------------------------------------------------
//   item     | stream in | req_type, source_node, target_node, degrees
//   result   | stream out| edge_count, hash_sum, hash_xor, error_code, match
//   apb      | csr       | node_total @0x0, view_mode @0x4, expected @0x8
//
// the front end takes one item a cycle while the queue has room
// each valid edge is hashed in the back end before the next one is taken,
// on the shared 32x32 multiplier doing three partial products per mix round
// rejected and ignored edges are not queued and never reach the back end
// an end marker leaves the queue once the result register is free
// reset clears control state, csr registers and sums; no clearing pass
// ----------------------------------------------------------------------------
module csr_edge_view_validator_unit
    import cevv_pkg::*;
#(
    parameter int NODE_BITS   = 31,
    parameter int QUEUE_DEPTH = 4
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    cevv_in_if.sink     item,
    cevv_out_if.source  result
);

    cfg_t    cfg_reg;
    logic    cfg_write;
    logic    push;
    logic    pop;
    logic    full;
    logic    empty;
    qentry_t push_data;
    qentry_t head;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (cfg_write)
        begin
            unique case (paddr[3:2])
                REG_NODE_COUNT:     cfg_reg.node_total     <= pwdata[30:0];
                REG_VIEW_MODE:      cfg_reg.view_mode      <= pwdata[1:0];
                REG_EXPECTED_EDGES: cfg_reg.expected_edges <= pwdata[30:0];
                default:            ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[3:2])
            REG_NODE_COUNT:     prdata = {1'b0, cfg_reg.node_total};
            REG_VIEW_MODE:      prdata = {30'b0, cfg_reg.view_mode};
            REG_EXPECTED_EDGES: prdata = {1'b0, cfg_reg.expected_edges};
            default:            prdata = '0;
        endcase
    end

    cevv_front #(
        .NODE_BITS (NODE_BITS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .item      (item),
        .push      (push),
        .push_data (push_data),
        .full      (full)
    );

    cevv_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .full      (full),
        .pop       (pop),
        .head      (head),
        .empty     (empty)
    );

    cevv_back u_back (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg_reg),
        .pop    (pop),
        .head   (head),
        .empty  (empty),
        .result (result)
    );

endmodule

[hw/rtl/cevv_fifo.sv]
// ----------------------------------------------------------------------------
// cevv_fifo
// Short register queue between the check front end and the hash back end.
// ----------------------------------------------------------------------------
module cevv_fifo
    import cevv_pkg::*;
#(
    parameter int DEPTH = 4
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    push,
    input  qentry_t push_data,
    output logic    full,
    input  logic    pop,
    output qentry_t head,
    output logic    empty
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    qentry_t            entries_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [CNT_W-1:0]   count_reg;

    assign full  = (count_reg == CNT_W'(DEPTH));
    assign empty = (count_reg == '0);
    assign head  = entries_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entries_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    a_fifo_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("queue fill beyond depth");

endmodule

[hw/rtl/cevv_front.sv]
// ----------------------------------------------------------------------------
// cevv_front
// Accepts edge beats, checks row order, range, endpoint rule and sorting,
// and queues the edge key or the end marker.
// ----------------------------------------------------------------------------
module cevv_front
    import cevv_pkg::*;
#(
    parameter int NODE_BITS = 31
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  cfg_t    cfg,
    cevv_in_if.sink item,
    output logic    push,
    output qentry_t push_data,
    input  logic    full
);

    logic [NODE_BITS-1:0] last_row_reg;
    logic [NODE_BITS-1:0] last_tgt_reg;
    logic                 last_valid_reg;
    logic [2:0]           err_reg;

    logic                 accept;
    logic [NODE_BITS-1:0] src;
    logic [NODE_BITS-1:0] limit;
    logic [NODE_BITS-1:0] tgt_n;
    logic [31:0]          tgt_u;
    logic [31:0]          src32;
    logic                 range_bad;
    logic                 order_ok;
    logic                 prev_valid;
    logic                 dup;
    logic [2:0]           edge_err;
    logic [NODE_BITS-1:0] key_lo;
    logic [NODE_BITS-1:0] key_hi;
    logic                 edge_good;

    assign item.ready = !full;
    assign accept     = item.valid && !full;

    assign src   = item.source_node[NODE_BITS-1:0];
    assign limit = cfg.node_total[NODE_BITS-1:0];
    assign tgt_u = item.target_node;
    assign tgt_n = tgt_u[NODE_BITS-1:0];
    assign src32 = 32'(src);

    assign range_bad = item.target_node[31] || (tgt_u >= 32'(limit)) || (src >= limit);

    always_comb
    begin
        unique case (cfg.view_mode)
            MODE_LOWER: order_ok = tgt_u > src32;
            MODE_UPPER: order_ok = tgt_u < src32;
            default:
                order_ok = (item.src_deg < item.tgt_deg)
                        || ((item.src_deg == item.tgt_deg) && (src32 < tgt_u));
        endcase
    end

    // a new row starts with no previous target
    assign prev_valid = last_valid_reg && !(src > last_row_reg);
    assign dup        = prev_valid && (tgt_n <= last_tgt_reg);

    always_comb
    begin
        if (src < last_row_reg)
        begin
            edge_err = ERR_BACK;
        end
        else if (range_bad)
        begin
            edge_err = ERR_RANGE;
        end
        else if (!order_ok)
        begin
            edge_err = ERR_ORDER;
        end
        else if (dup)
        begin
            edge_err = ERR_DUP;
        end
        else
        begin
            edge_err = ERR_NONE;
        end
    end

    assign key_lo = (src < tgt_n) ? src : tgt_n;
    assign key_hi = (src < tgt_n) ? tgt_n : src;

    assign edge_good = accept && !item.req_type && (err_reg == ERR_NONE)
                    && (edge_err == ERR_NONE);

    assign push             = (accept && item.req_type) || edge_good;
    assign push_data.is_end = item.req_type;
    assign push_data.err    = err_reg;
    assign push_data.key    = {32'(key_lo), 32'(key_hi)};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_row_reg   <= '0;
            last_tgt_reg   <= '0;
            last_valid_reg <= 1'b0;
            err_reg        <= ERR_NONE;
        end
        else if (accept)
        begin
            if (item.req_type)
            begin
                last_row_reg   <= '0;
                last_valid_reg <= 1'b0;
                err_reg        <= ERR_NONE;
            end
            else if (err_reg == ERR_NONE)
            begin
                if (edge_err != ERR_NONE)
                begin
                    err_reg <= edge_err;
                end
                else
                begin
                    last_row_reg   <= src;
                    last_tgt_reg   <= tgt_n;
                    last_valid_reg <= 1'b1;
                end
            end
        end
    end

    a_err_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        (err_reg != ERR_NONE && !(accept && item.req_type)) |=> err_reg == $past(err_reg))
        else $error("latched error changed before end of stream");

    a_no_edge_after_err: assert property (@(posedge clk) disable iff (!rst_n)
        (err_reg != ERR_NONE && push) |-> push_data.is_end)
        else $error("edge queued after an error was latched");

endmodule

[hw/rtl/cevv_back.sv]
// ----------------------------------------------------------------------------
// cevv_back
// Hashes queued edge keys with one shared 32x32 multiplier, accumulates
// count, sum and xor, and drives the result register on end markers.
// ----------------------------------------------------------------------------
module cevv_back
    import cevv_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  cfg_t          cfg,
    output logic          pop,
    input  qentry_t       head,
    input  logic          empty,
    cevv_out_if.source    result
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_M0   = 3'd1;
    localparam logic [2:0] ST_M1   = 3'd2;
    localparam logic [2:0] ST_M2   = 3'd3;
    localparam logic [2:0] ST_M3   = 3'd4;
    localparam logic [2:0] ST_ACC  = 3'd5;

    logic [2:0]  state_reg;
    logic [2:0]  state_next;
    logic        round_reg;
    logic [63:0] v_reg;
    logic [63:0] prod_reg;
    logic [63:0] acc_reg;
    logic [30:0] count_reg;
    logic [63:0] sum_reg;
    logic [63:0] xor_reg;

    logic        out_valid_reg;
    logic [30:0] out_count_reg;
    logic [63:0] out_sum_reg;
    logic [63:0] out_xor_reg;
    logic [2:0]  out_err_reg;
    logic        out_match_reg;

    logic        take_end;
    logic        take_edge;
    logic [63:0] mix_in;
    logic [63:0] mix_a;
    logic [63:0] mul_k;
    logic [31:0] mul_a;
    logic [31:0] mul_b;
    logic [63:0] mul_p;
    logic [63:0] fold;
    logic [63:0] v_fin;

    assign take_end  = (state_reg == ST_IDLE) && !empty && head.is_end
                    && (!out_valid_reg || result.ready);
    assign take_edge = (state_reg == ST_IDLE) && !empty && !head.is_end;
    assign pop       = take_end || take_edge;

    assign mix_in = head.key + MIX_GOLDEN;
    assign mix_a  = mix_in ^ (mix_in >> 30);
    assign mul_k  = round_reg ? MIX_MUL_B : MIX_MUL_A;

    // low 64 bits of v * k from three partial products
    always_comb
    begin
        case (state_reg)
            ST_M1:
            begin
                mul_a = v_reg[31:0];
                mul_b = mul_k[63:32];
            end
            ST_M2:
            begin
                mul_a = v_reg[63:32];
                mul_b = mul_k[31:0];
            end
            default:
            begin
                mul_a = v_reg[31:0];
                mul_b = mul_k[31:0];
            end
        endcase
    end

    assign mul_p = {32'b0, mul_a} * {32'b0, mul_b};
    assign fold  = acc_reg + {prod_reg[31:0], 32'b0};
    assign v_fin = round_reg ? (fold ^ (fold >> 31)) : (fold ^ (fold >> 27));

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (take_edge) state_next = ST_M0;
            ST_M0:   state_next = ST_M1;
            ST_M1:   state_next = ST_M2;
            ST_M2:   state_next = ST_M3;
            ST_M3:   state_next = round_reg ? ST_ACC : ST_M0;
            ST_ACC:  state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (take_edge)
        begin
            v_reg <= mix_a;
        end
        else if (state_reg == ST_M3)
        begin
            v_reg <= v_fin;
        end
        if (state_reg == ST_M0 || state_reg == ST_M1 || state_reg == ST_M2)
        begin
            prod_reg <= mul_p;
        end
        if (state_reg == ST_M1)
        begin
            acc_reg <= prod_reg;
        end
        else if (state_reg == ST_M2)
        begin
            acc_reg <= fold;
        end
        if (take_end)
        begin
            out_count_reg <= count_reg;
            out_sum_reg   <= sum_reg;
            out_xor_reg   <= xor_reg;
            out_err_reg   <= head.err;
            out_match_reg <= (count_reg == cfg.expected_edges);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            round_reg     <= 1'b0;
            count_reg     <= '0;
            sum_reg       <= '0;
            xor_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (take_edge)
            begin
                round_reg <= 1'b0;
            end
            else if (state_reg == ST_M3)
            begin
                round_reg <= 1'b1;
            end
            if (take_end)
            begin
                count_reg <= '0;
                sum_reg   <= '0;
                xor_reg   <= '0;
            end
            else if (state_reg == ST_ACC)
            begin
                // count saturates at all ones
                if (count_reg != '1)
                begin
                    count_reg <= count_reg + 1'b1;
                end
                sum_reg <= sum_reg + v_reg;
                xor_reg <= xor_reg ^ v_reg;
            end
            if (take_end)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign result.valid       = out_valid_reg;
    assign result.edge_count  = out_count_reg;
    assign result.hash_sum    = out_sum_reg;
    assign result.hash_xor    = out_xor_reg;
    assign result.error_code  = out_err_reg;
    assign result.count_match = out_match_reg;

    a_acc_second_round: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_ACC) |-> round_reg)
        else $error("accumulate reached before second mix round");

    a_sum_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_ACC && !take_end) |=> $stable(sum_reg) && $stable(xor_reg))
        else $error("fingerprint moved while no hash was ready");

endmodule
